// ----- rtl/core/ekrgb_pkg.sv -----
// Shared types and constants for the encoder and key RGB setting controller.
// No dependencies; imported by the channel interfaces and the core.
package ekrgb_pkg;

  localparam int unsigned POS_W    = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned STEP_W   = 7;
  localparam int unsigned SCALE_W  = 6;
  localparam int unsigned PWM_W    = 14;
  localparam int unsigned MS_CFG_W = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [MS_CFG_W-1:0] LONG_PRESS_RST  = 16'd3000;
  localparam logic [MS_CFG_W-1:0] IDLE_TIMEOUT_RST = 16'd5000;
  localparam logic [STEP_W-1:0]   LEVEL_STEP_RST  = 7'd10;
  localparam logic [LEVEL_W-1:0]  LEVEL_MAX_RST   = 8'd100;
  localparam logic [LEVEL_W-1:0]  DEFAULT_RED_RST = 8'd50;
  localparam logic [SCALE_W-1:0]  PWM_SCALE_RST   = 6'd10;

  typedef enum logic [1:0] {
    FN_TICK,
    FN_POS,
    FN_KEY
  } func_t;

  typedef enum logic [2:0] {
    EV_NONE,
    EV_ENTER,
    EV_SAVED,
    EV_CANCEL,
    EV_ROTATE
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LONG_PRESS,
    REG_IDLE_TIMEOUT,
    REG_LEVEL_STEP,
    REG_LEVEL_MAX,
    REG_DEFAULT_RED,
    REG_PWM_SCALE
  } reg_idx_t;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  localparam logic signed [1:0] DIR_CW  = 2'sd1;
  localparam logic signed [1:0] DIR_CCW = -2'sd1;

endpackage

// ----- rtl/core/ekrgb_in_if.sv -----
// Input channel interface: valid/ready handshake with the event item payload.
// Depends on ekrgb_pkg for field widths.
interface ekrgb_in_if import ekrgb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [POS_W-1:0]   position;
  logic               key_level;

  modport source (output valid, output func, output position, output key_level, input ready);
  modport sink (input valid, input func, input position, input key_level, output ready);
endinterface

// ----- rtl/core/ekrgb_out_if.sv -----
// Result channel interface: valid/ready handshake with PWM values and status.
// Depends on ekrgb_pkg for field widths.
interface ekrgb_out_if import ekrgb_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [PWM_W-1:0]         pwm_red;
  logic [PWM_W-1:0]         pwm_green;
  logic [PWM_W-1:0]         pwm_blue;
  logic                     setting_active;
  logic [1:0]               channel;
  logic signed [1:0]        turn_direction;
  logic signed [POS_W-1:0]  movement;
  logic [TIME_W-1:0]        turn_period_ms;
  logic [2:0]               event_res;

  modport source (output valid, output pwm_red, output pwm_green, output pwm_blue,
                  output setting_active, output channel, output turn_direction,
                  output movement, output turn_period_ms, output event_res,
                  input ready);
  modport sink (input valid, input pwm_red, input pwm_green, input pwm_blue,
                input setting_active, input channel, input turn_direction,
                input movement, input turn_period_ms, input event_res,
                output ready);
endinterface

// ----- rtl/core/encoder_key_rgb_setting_controller_core.sv -----
// Encoder and key RGB setting controller core.
// Latency: a result is valid in the cycle after its item is accepted.
// Throughput: one item per cycle; the result register is the only stage, and
// an item is taken whenever that register is empty or its result is being taken.
// Reset (synchronous, rst_n low) restores the register defaults and clears all
// state, with red at its default level and green and blue at zero.
module encoder_key_rgb_setting_controller_core
  import ekrgb_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  ekrgb_in_if.sink             in_ch,
  ekrgb_out_if.source          out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [MS_CFG_W-1:0] long_press_r;
  logic [MS_CFG_W-1:0] idle_timeout_r;
  logic [STEP_W-1:0]   level_step_r;
  logic [LEVEL_W-1:0]  level_max_r;
  logic [LEVEL_W-1:0]  default_red_r;
  logic [SCALE_W-1:0]  pwm_scale_r;

  logic [TIME_W-1:0]      ms_r, ms_nxt;
  logic [COUNT_WIDTH-1:0] last_pos_r, last_pos_nxt;
  logic [TIME_W-1:0]      last_move_r, last_move_nxt;
  logic [TIME_W-1:0]      period_r, period_nxt;
  logic signed [1:0]      dir_r, dir_nxt;
  logic                   key_down_r, key_down_nxt;
  logic [TIME_W-1:0]      key_time_r, key_time_nxt;
  logic                   long_taken_r, long_taken_nxt;
  logic                   setting_r, setting_nxt;
  logic [1:0]             sel_r, sel_nxt;
  logic [TIME_W-1:0]      last_rot_r, last_rot_nxt;
  logic [LEVEL_W-1:0]     lvl_r [3];
  logic [LEVEL_W-1:0]     lvl_nxt [3];

  logic                   out_valid_r;
  logic                   accept;

  logic [COUNT_WIDTH-1:0]        pos_cw;
  logic signed [COUNT_WIDTH-1:0] delta;
  logic [1:0]                    ch;
  logic signed [LEVEL_W+1:0]     lvl_sum;
  logic signed [POS_W-1:0]       movement_nxt;
  event_t                        ev_nxt;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign out_ch.valid = out_valid_r;

  assign pos_cw = COUNT_WIDTH'(in_ch.position);
  assign delta  = $signed(pos_cw - last_pos_r);
  assign ch     = (sel_r < CH_BLUE) ? sel_r : CH_BLUE;

  always_comb begin
    ms_nxt         = ms_r;
    last_pos_nxt   = last_pos_r;
    last_move_nxt  = last_move_r;
    period_nxt     = period_r;
    dir_nxt        = dir_r;
    key_down_nxt   = key_down_r;
    key_time_nxt   = key_time_r;
    long_taken_nxt = long_taken_r;
    setting_nxt    = setting_r;
    sel_nxt        = sel_r;
    last_rot_nxt   = last_rot_r;
    lvl_nxt        = lvl_r;
    movement_nxt   = '0;
    ev_nxt         = EV_NONE;
    lvl_sum        = '0;

    case (in_ch.func)
      FN_TICK: begin
        ms_nxt = ms_r + 32'd1;
      end
      FN_POS: begin
        movement_nxt = POS_W'(delta);
        if (delta != '0) begin
          dir_nxt = (delta > 0) ? DIR_CW : DIR_CCW;
          if (last_move_r != '0) begin
            period_nxt = ms_r - last_move_r;
          end
          last_pos_nxt  = pos_cw;
          last_move_nxt = ms_r;
          last_rot_nxt  = ms_r;
          if (setting_r) begin
            if (delta > 0) begin
              lvl_sum = $signed({2'b00, lvl_r[ch]}) + $signed({3'b000, level_step_r});
            end else begin
              lvl_sum = $signed({2'b00, lvl_r[ch]}) - $signed({3'b000, level_step_r});
            end
            if (lvl_sum > $signed({2'b00, level_max_r})) begin
              lvl_sum = $signed({2'b00, level_max_r});
            end
            if (lvl_sum < 0) begin
              lvl_sum = '0;
            end
            lvl_nxt[ch] = LEVEL_W'(lvl_sum);
          end
          ev_nxt = EV_ROTATE;
        end
      end
      FN_KEY: begin
        if (!in_ch.key_level) begin
          key_down_nxt   = 1'b1;
          key_time_nxt   = ms_r;
          long_taken_nxt = 1'b0;
        end else begin
          key_down_nxt = 1'b0;
          if (!long_taken_r) begin
            if (!setting_r) begin
              setting_nxt  = 1'b1;
              sel_nxt      = CH_RED;
              last_rot_nxt = ms_r;
              ev_nxt       = EV_ENTER;
            end else begin
              case (sel_r)
                CH_RED:   sel_nxt = CH_GREEN;
                CH_GREEN: sel_nxt = CH_BLUE;
                CH_BLUE:  sel_nxt = CH_RED;
                default:  sel_nxt = CH_GREEN;
              endcase
              if (sel_nxt == CH_RED) begin
                setting_nxt = 1'b0;
                ev_nxt      = EV_SAVED;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase

    if (!setting_nxt && key_down_nxt && !long_taken_nxt &&
        (ms_nxt - key_time_nxt) >= {16'd0, long_press_r}) begin
      long_taken_nxt = 1'b1;
      setting_nxt    = 1'b1;
      sel_nxt        = CH_RED;
      last_rot_nxt   = ms_nxt;
      ev_nxt         = EV_ENTER;
    end

    if (setting_nxt && (ms_nxt - last_rot_nxt) >= {16'd0, idle_timeout_r}) begin
      setting_nxt = 1'b0;
      lvl_nxt[0]  = default_red_r;
      lvl_nxt[1]  = '0;
      lvl_nxt[2]  = '0;
      ev_nxt      = EV_CANCEL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_r   <= LONG_PRESS_RST;
      idle_timeout_r <= IDLE_TIMEOUT_RST;
      level_step_r   <= LEVEL_STEP_RST;
      level_max_r    <= LEVEL_MAX_RST;
      default_red_r  <= DEFAULT_RED_RST;
      pwm_scale_r    <= PWM_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LONG_PRESS:   long_press_r   <= cfg_data;
        REG_IDLE_TIMEOUT: idle_timeout_r <= cfg_data;
        REG_LEVEL_STEP:   level_step_r   <= cfg_data[STEP_W-1:0];
        REG_LEVEL_MAX:    level_max_r    <= cfg_data[LEVEL_W-1:0];
        REG_DEFAULT_RED:  default_red_r  <= cfg_data[LEVEL_W-1:0];
        REG_PWM_SCALE:    pwm_scale_r    <= cfg_data[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_r         <= '0;
      last_pos_r   <= '0;
      last_move_r  <= '0;
      period_r     <= '0;
      dir_r        <= '0;
      key_down_r   <= 1'b0;
      key_time_r   <= '0;
      long_taken_r <= 1'b0;
      setting_r    <= 1'b0;
      sel_r        <= CH_RED;
      last_rot_r   <= '0;
      lvl_r[0]     <= DEFAULT_RED_RST;
      lvl_r[1]     <= '0;
      lvl_r[2]     <= '0;
    end else if (accept) begin
      ms_r         <= ms_nxt;
      last_pos_r   <= last_pos_nxt;
      last_move_r  <= last_move_nxt;
      period_r     <= period_nxt;
      dir_r        <= dir_nxt;
      key_down_r   <= key_down_nxt;
      key_time_r   <= key_time_nxt;
      long_taken_r <= long_taken_nxt;
      setting_r    <= setting_nxt;
      sel_r        <= sel_nxt;
      last_rot_r   <= last_rot_nxt;
      lvl_r        <= lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ch.pwm_red        <= PWM_W'({6'd0, lvl_nxt[0]}) * PWM_W'(pwm_scale_r);
      out_ch.pwm_green      <= PWM_W'({6'd0, lvl_nxt[1]}) * PWM_W'(pwm_scale_r);
      out_ch.pwm_blue       <= PWM_W'({6'd0, lvl_nxt[2]}) * PWM_W'(pwm_scale_r);
      out_ch.setting_active <= setting_nxt;
      out_ch.channel        <= sel_nxt;
      out_ch.turn_direction <= dir_nxt;
      out_ch.movement       <= movement_nxt;
      out_ch.turn_period_ms <= period_nxt;
      out_ch.event_res      <= ev_nxt;
    end
  end

`ifndef SYNTH
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("Accepted item produced no result");

  a_enter_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ch.event_res == EV_ENTER) |->
      (out_ch.setting_active && out_ch.channel == CH_RED))
    else $error("Set mode entry reported without set mode on red");

  a_leave_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_ch.event_res == EV_SAVED || out_ch.event_res == EV_CANCEL)) |->
      !out_ch.setting_active)
    else $error("Save or cancel reported while still in set mode");

  a_cancel_levels: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ch.event_res == EV_CANCEL) |->
      (out_ch.pwm_green == '0 && out_ch.pwm_blue == '0))
    else $error("Cancel left green or blue level set");
`endif

endmodule

// ----- dv/tb_encoder_key_rgb_setting_controller_core.sv -----
// Testbench for the encoder and key RGB setting controller core: drives ticks, position
// samples and key edges, predicts every result and compares it field by field.
// Depends on ekrgb_pkg, ekrgb_in_if, ekrgb_out_if and the core itself.
`timescale 1ns / 100ps

module tb_encoder_key_rgb_setting_controller_core;
  import ekrgb_pkg::*;

  localparam logic [1:0] FN_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 82;

  typedef struct {
    logic [PWM_W-1:0]        pwm_red;
    logic [PWM_W-1:0]        pwm_green;
    logic [PWM_W-1:0]        pwm_blue;
    logic                    setting_active;
    logic [1:0]              channel;
    logic signed [1:0]       turn_direction;
    logic signed [POS_W-1:0] movement;
    logic [TIME_W-1:0]       turn_period_ms;
    logic [2:0]              event_res;
  } rgb_status_t;

  class rgb_status_tracker;
    bit [MS_CFG_W-1:0] long_press_ms;
    bit [MS_CFG_W-1:0] idle_timeout_ms;
    bit [STEP_W-1:0]   level_step;
    bit [LEVEL_W-1:0]  level_max;
    bit [LEVEL_W-1:0]  default_red;
    bit [SCALE_W-1:0]  pwm_scale;
    bit [TIME_W-1:0]   ms_clock;
    bit [TIME_W-1:0]   last_move_time;
    bit [TIME_W-1:0]   move_period;
    bit [TIME_W-1:0]   key_down_time;
    bit [TIME_W-1:0]   last_turn_time;
    bit [POS_W-1:0]    last_position;
    bit signed [1:0]   direction;
    bit                key_down;
    bit                long_press_taken;
    bit                in_setting;
    bit [1:0]          channel;
    bit [LEVEL_W-1:0]  levels [3];
    rgb_status_t       expected_status [$];
    int                fails;

    function new();
      long_press_ms = LONG_PRESS_RST;
      idle_timeout_ms = IDLE_TIMEOUT_RST;
      level_step = LEVEL_STEP_RST;
      level_max = LEVEL_MAX_RST;
      default_red = DEFAULT_RED_RST;
      pwm_scale = PWM_SCALE_RST;
      levels[CH_RED] = DEFAULT_RED_RST;
      levels[CH_GREEN] = '0;
      levels[CH_BLUE] = '0;
      fails = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_LONG_PRESS:   long_press_ms = data;
        REG_IDLE_TIMEOUT: idle_timeout_ms = data;
        REG_LEVEL_STEP:   level_step = data[STEP_W-1:0];
        REG_LEVEL_MAX:    level_max = data[LEVEL_W-1:0];
        REG_DEFAULT_RED:  default_red = data[LEVEL_W-1:0];
        REG_PWM_SCALE:    pwm_scale = data[SCALE_W-1:0];
        default: ;
      endcase
    endfunction

    function void enter_setting();
      in_setting = 1'b1;
      channel = CH_RED;
      last_turn_time = ms_clock;
    endfunction

    function int pending();
      return expected_status.size();
    endfunction

    function void note_item(logic [1:0] fn, logic [POS_W-1:0] pos, logic key);
      logic signed [POS_W-1:0] delta;
      logic [2:0] ev;
      int lvl;
      rgb_status_t s;
      delta = '0;
      ev = EV_NONE;
      case (fn)
        FN_TICK: ms_clock = ms_clock + 1;
        FN_POS: begin
          delta = pos - last_position;
          if (delta != 0) begin
            direction = (delta > 0) ? DIR_CW : DIR_CCW;
            if (last_move_time != 0) move_period = ms_clock - last_move_time;
            last_position = pos;
            last_move_time = ms_clock;
            last_turn_time = ms_clock;
            if (in_setting) begin
              lvl = int'(levels[channel]) +
                    ((delta > 0) ? int'(level_step) : -int'(level_step));
              if (lvl > int'(level_max)) lvl = int'(level_max);
              if (lvl < 0) lvl = 0;
              levels[channel] = LEVEL_W'(lvl);
            end
            ev = EV_ROTATE;
          end
        end
        FN_KEY: begin
          if (!key) begin
            key_down = 1'b1;
            key_down_time = ms_clock;
            long_press_taken = 1'b0;
          end else begin
            key_down = 1'b0;
            if (!long_press_taken) begin
              if (!in_setting) begin
                enter_setting();
                ev = EV_ENTER;
              end else begin
                channel = (channel == CH_BLUE) ? CH_RED : channel + 2'd1;
                if (channel == CH_RED) begin
                  in_setting = 1'b0;
                  ev = EV_SAVED;
                end
              end
            end
          end
        end
        default: ;
      endcase

      if (!in_setting && key_down && !long_press_taken &&
          (ms_clock - key_down_time) >= TIME_W'(long_press_ms)) begin
        long_press_taken = 1'b1;
        enter_setting();
        ev = EV_ENTER;
      end
      if (in_setting && (ms_clock - last_turn_time) >= TIME_W'(idle_timeout_ms)) begin
        in_setting = 1'b0;
        levels[CH_RED] = default_red;
        levels[CH_GREEN] = '0;
        levels[CH_BLUE] = '0;
        ev = EV_CANCEL;
      end

      s.pwm_red = PWM_W'(int'(levels[CH_RED]) * int'(pwm_scale));
      s.pwm_green = PWM_W'(int'(levels[CH_GREEN]) * int'(pwm_scale));
      s.pwm_blue = PWM_W'(int'(levels[CH_BLUE]) * int'(pwm_scale));
      s.setting_active = in_setting;
      s.channel = channel;
      s.turn_direction = direction;
      s.movement = delta;
      s.turn_period_ms = move_period;
      s.event_res = ev;
      expected_status.push_back(s);
    endfunction

    function void cmp_field(string name, logic signed [63:0] want, logic signed [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        fails++;
      end
    endfunction

    function void check_status(rgb_status_t got);
      rgb_status_t want;
      if (expected_status.size() == 0) begin
        $error("result arrived with no item outstanding");
        fails++;
        return;
      end
      want = expected_status.pop_front();
      cmp_field("pwm_red", want.pwm_red, got.pwm_red);
      cmp_field("pwm_green", want.pwm_green, got.pwm_green);
      cmp_field("pwm_blue", want.pwm_blue, got.pwm_blue);
      cmp_field("setting_active", want.setting_active, got.setting_active);
      cmp_field("channel", want.channel, got.channel);
      cmp_field("turn_direction", want.turn_direction, got.turn_direction);
      cmp_field("movement", want.movement, got.movement);
      cmp_field("turn_period_ms", want.turn_period_ms, got.turn_period_ms);
      cmp_field("event_res", want.event_res, got.event_res);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  ekrgb_in_if in_ch();
  ekrgb_out_if out_ch();

  rgb_status_tracker sb;
  int send_idle_pct = 23;
  int recv_idle_pct = 45;
  int items_sent = 0;
  int quiet_cycles = 0;
  logic [POS_W-1:0] pos_track = '0;

  encoder_key_rgb_setting_controller_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : watch_channels
    rgb_status_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.pwm_red = out_ch.pwm_red;
        got.pwm_green = out_ch.pwm_green;
        got.pwm_blue = out_ch.pwm_blue;
        got.setting_active = out_ch.setting_active;
        got.channel = out_ch.channel;
        got.turn_direction = out_ch.turn_direction;
        got.movement = out_ch.movement;
        got.turn_period_ms = out_ch.turn_period_ms;
        got.event_res = out_ch.event_res;
        sb.check_status(got);
      end
      if (in_ch.valid && in_ch.ready) begin
        sb.note_item(in_ch.func, in_ch.position, in_ch.key_level);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("encoder_key_rgb_setting_controller_core test failed");
        $finish;
      end
    end
  end

  task automatic send_item(logic [1:0] fn, logic [POS_W-1:0] pos, logic key);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= fn;
    in_ch.position <= pos;
    in_ch.key_level <= key;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  // Unused upper bits of the narrow registers carry noise, which must be dropped.
  task automatic program_regs(int lp, int idle, int step, int lmax, int red, int scale);
    logic [CFG_W-1:0] noise;
    noise = CFG_W'($urandom);
    write_reg(REG_LONG_PRESS, CFG_W'(lp));
    write_reg(REG_IDLE_TIMEOUT, CFG_W'(idle));
    write_reg(REG_LEVEL_STEP, {noise[CFG_W-1:STEP_W], STEP_W'(step)});
    write_reg(REG_LEVEL_MAX, {noise[CFG_W-1:LEVEL_W], LEVEL_W'(lmax)});
    write_reg(REG_DEFAULT_RED, {noise[CFG_W-1:LEVEL_W], LEVEL_W'(red)});
    write_reg(REG_PWM_SCALE, {noise[CFG_W-1:SCALE_W], SCALE_W'(scale)});
  endtask

  task automatic rand_action();
    int pick;
    int n;
    logic [POS_W-1:0] p;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      repeat (n) send_item(FN_TICK, POS_W'($urandom), 1'($urandom));
    end else if (pick < 60) begin
      if ($urandom_range(0, 9) == 0) p = POS_W'($urandom);
      else p = pos_track + POS_W'($urandom_range(0, 8)) - POS_W'(4);
      pos_track = p;
      send_item(FN_POS, p, 1'($urandom));
    end else if (pick < 85) begin
      send_item(FN_KEY, POS_W'($urandom), 1'b0);
      repeat ($urandom_range(0, 15)) send_item(FN_TICK, POS_W'($urandom), 1'($urandom));
      send_item(FN_KEY, POS_W'($urandom), 1'b1);
    end else if (pick < 95) begin
      send_item(FN_KEY, POS_W'($urandom), 1'($urandom));
    end else begin
      send_item(FN_SPARE, POS_W'($urandom), 1'($urandom));
    end
  endtask

  initial begin : stimulus
    int target;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.func = FN_TICK;
    in_ch.position = '0;
    in_ch.key_level = 1'b1;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Register reset values: signed wrap of the position, a release with no press,
    // a full pass through the channels and the unused function code.
    send_item(FN_POS, 16'h0001, 1'b1);
    send_item(FN_TICK, 16'hFFFF, 1'b0);
    send_item(FN_POS, 16'h0000, 1'b0);
    send_item(FN_TICK, 16'h0000, 1'b1);
    send_item(FN_POS, 16'h8000, 1'b1);
    send_item(FN_POS, 16'hFFFF, 1'b0);
    send_item(FN_POS, 16'hFFFF, 1'b0);
    send_item(FN_KEY, 16'h0000, 1'b1);
    send_item(FN_POS, 16'hFFFE, 1'b0);
    send_item(FN_KEY, 16'h0000, 1'b0);
    send_item(FN_KEY, 16'h0000, 1'b1);
    send_item(FN_POS, 16'hFFFF, 1'b0);
    send_item(FN_KEY, 16'h0000, 1'b1);
    send_item(FN_KEY, 16'h0000, 1'b1);
    send_item(FN_SPARE, 16'hFFFF, 1'b1);
    wait_drained();

    // A long press followed by its release, then the idle timeout cancels.
    program_regs(2, 4, 37, 90, 200, 33);
    send_item(FN_KEY, 16'h0000, 1'b0);
    send_item(FN_TICK, 16'h0000, 1'b0);
    send_item(FN_TICK, 16'h0000, 1'b0);
    send_item(FN_KEY, 16'h0000, 1'b1);
    repeat (4) send_item(FN_TICK, 16'h0000, 1'b1);
    wait_drained();
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, '1);
    pos_track = 16'hFFFF;

    for (int phase = 0; phase < 6; phase++) begin
      case (phase / 2)
        0: begin send_idle_pct = 23; recv_idle_pct = 45; end
        1: begin send_idle_pct = 45; recv_idle_pct = 23; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (phase)
        0: program_regs(0, 65535, 100, 255, 255, 63);
        2: program_regs(65535, 0, 0, 0, 0, 0);
        default: program_regs($urandom_range(0, 12), $urandom_range(2, 40),
                              $urandom_range(0, 100), $urandom_range(0, 255),
                              $urandom_range(0, 255), $urandom_range(0, 63));
      endcase
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) rand_action();
      wait_drained();
    end

    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("encoder_key_rgb_setting_controller_core test passed");
    end else begin
      $display("encoder_key_rgb_setting_controller_core test failed");
    end
    $finish;
  end

endmodule
